// ----- design/ttpt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared types and constants for the two-touch pinch tracker.
// ----------------------------------------------------------------------------
package ttpt_pkg;

	localparam int CoordBits  = 12;
	localparam int IdBits     = 8;
	localparam int DistBits   = CoordBits + 1;
	localparam int ThreshBits = 13;
	localparam int CmpBits    = (DistBits > ThreshBits) ? DistBits : ThreshBits;

	localparam logic [ThreshBits-1:0] ThreshReset = ThreshBits'(20);

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic [DistBits-1:0]  dist_t;

	typedef enum logic [1:0] {
		KIND_DOWN   = 2'd0,
		KIND_MOVE   = 2'd1,
		KIND_UP     = 2'd2,
		KIND_CANCEL = 2'd3
	} kind_t;

	localparam logic signed [1:0] ZoomNone = 2'sd0;
	localparam logic signed [1:0] ZoomIn   = 2'sd1;
	localparam logic signed [1:0] ZoomOut  = -2'sd1;

endpackage

// ----- design/two_touch_pinch_tracker.sv -----
// ----------------------------------------------------------------------------
// two_touch_pinch_tracker
// Tracks two touch contacts, emits zoom steps on pinch and taps on release.
// ----------------------------------------------------------------------------
// One event per clock while the output is not stalled: an item is taken into
// the input register, resolved combinationally against the two contact slots,
// and its result lands in the result register, so a result is offered from
// the result register once its item leaves the input register. The input side
// stalls only while a finished result waits at the output and the input
// register is full. Every item gives exactly one result.
// The threshold register may be written at any time the block is idle.
module two_touch_pinch_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ttpt_pkg::ThreshBits-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic [ttpt_pkg::IdBits-1:0]        contact_id,
	input  logic [ttpt_pkg::CoordBits-1:0]     pos_x,
	input  logic [ttpt_pkg::CoordBits-1:0]     pos_y,
	input  logic                               pinch_enabled,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [1:0]                  zoom_step,
	output logic                               tap_valid,
	output logic [ttpt_pkg::CoordBits-1:0]     tap_x,
	output logic [ttpt_pkg::CoordBits-1:0]     tap_y
);
	import ttpt_pkg::*;

	logic [ThreshBits-1:0] thresh_q;

	// input register
	logic               valid_s1;
	kind_t              kind_s1;
	logic [IdBits-1:0]  id_s1;
	coord_t             x_s1, y_s1;
	logic               en_s1;

	// tracker state
	logic [1:0]         act_q;
	logic [IdBits-1:0]  cid_q [2];
	coord_t             sx_q [2];
	coord_t             sy_q [2];
	dist_t              ref_q;
	logic               pinch_q;

	// result register
	logic               out_valid_q;
	logic signed [1:0]  zoom_q;
	logic               tap_q;
	coord_t             tx_q, ty_q;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// slot lookup
	logic       m0, m1, hit, take, sel;
	logic [1:0] act_nxt;
	coord_t     nx0, nx1, ny0, ny1, dx, dy;
	dist_t      pdist;
	logic [CmpBits-1:0] d_w, r_w, th_w;
	logic               grow, shrink;

	dist_t              ref_nxt;
	logic               pinch_nxt;
	logic signed [1:0]  zoom_nxt;
	logic               tap_nxt;
	coord_t             tx_nxt, ty_nxt;

	always_comb begin
		m0   = act_q[0] && (cid_q[0] == id_s1);
		m1   = act_q[1] && (cid_q[1] == id_s1);
		hit  = m0 || m1;
		if (kind_s1 == KIND_DOWN) begin
			take = hit || !act_q[0] || !act_q[1];
			sel  = hit ? m1 : act_q[0];
		end else begin
			take = hit;
			sel  = m1;
		end

		act_nxt = act_q;
		if (take) begin
			case (kind_s1)
				KIND_DOWN:             act_nxt[sel] = 1'b1;
				KIND_UP, KIND_CANCEL:  act_nxt[sel] = 1'b0;
				default:               act_nxt = act_q;
			endcase
		end

		nx0 = (take && !sel) ? x_s1 : sx_q[0];
		ny0 = (take && !sel) ? y_s1 : sy_q[0];
		nx1 = (take && sel)  ? x_s1 : sx_q[1];
		ny1 = (take && sel)  ? y_s1 : sy_q[1];

		dx    = (nx0 > nx1) ? (nx0 - nx1) : (nx1 - nx0);
		dy    = (ny0 > ny1) ? (ny0 - ny1) : (ny1 - ny0);
		pdist = (dx > dy) ? ({1'b0, dx} + {2'b00, dy[CoordBits-1:1]})
		                  : ({1'b0, dy} + {2'b00, dx[CoordBits-1:1]});

		d_w  = CmpBits'(pdist);
		r_w  = CmpBits'(ref_q);
		th_w = (thresh_q == '0) ? CmpBits'(1) : CmpBits'(thresh_q);
		grow   = (d_w >= r_w) && ((d_w - r_w) >= th_w);
		shrink = (d_w < r_w) && ((r_w - d_w) >= th_w);

		ref_nxt   = ref_q;
		pinch_nxt = pinch_q;
		zoom_nxt  = ZoomNone;
		tap_nxt   = 1'b0;
		tx_nxt    = '0;
		ty_nxt    = '0;

		if (take) begin
			case (kind_s1)
				KIND_DOWN: begin
					if (act_nxt[0] && act_nxt[1]) begin
						ref_nxt   = pdist;
						pinch_nxt = 1'b1;
					end else begin
						pinch_nxt = 1'b0;
					end
				end
				KIND_MOVE: begin
					if (act_q[0] && act_q[1] && en_s1) begin
						if (grow) begin
							zoom_nxt = ZoomIn;
							ref_nxt  = pdist;
						end else if (shrink) begin
							zoom_nxt = ZoomOut;
							ref_nxt  = pdist;
						end
					end
				end
				default: begin
					if (kind_s1 != KIND_UP || pinch_q) begin
						if (act_nxt == 2'b00)
							pinch_nxt = 1'b0;
					end else begin
						tap_nxt = 1'b1;
						tx_nxt  = x_s1;
						ty_nxt  = y_s1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind_t'(kind);
			id_s1   <= contact_id;
			x_s1    <= pos_x;
			y_s1    <= pos_y;
			en_s1   <= pinch_enabled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= '0;
			cid_q[0] <= '0;
			cid_q[1] <= '0;
			sx_q[0]  <= '0;
			sx_q[1]  <= '0;
			sy_q[0]  <= '0;
			sy_q[1]  <= '0;
			ref_q    <= '0;
			pinch_q  <= 1'b0;
		end else if (advance) begin
			act_q    <= act_nxt;
			sx_q[0]  <= nx0;
			sx_q[1]  <= nx1;
			sy_q[0]  <= ny0;
			sy_q[1]  <= ny1;
			ref_q    <= ref_nxt;
			pinch_q  <= pinch_nxt;
			if (take && kind_s1 == KIND_DOWN)
				cid_q[sel] <= id_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zoom_q <= zoom_nxt;
			tap_q  <= tap_nxt;
			tx_q   <= tx_nxt;
			ty_q   <= ty_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign zoom_step = zoom_q;
	assign tap_valid = tap_q;
	assign tap_x     = tx_q;
	assign tap_y     = ty_q;

endmodule

// ----- design/ttpt_checker.sv -----
// ----------------------------------------------------------------------------
// ttpt_checker
// Port-level checks for the two-touch pinch tracker.
// ----------------------------------------------------------------------------
module ttpt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [1:0]              zoom_step,
	input logic                           tap_valid,
	input logic [ttpt_pkg::CoordBits-1:0] tap_x,
	input logic [ttpt_pkg::CoordBits-1:0] tap_y
);
	import ttpt_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(zoom_step) && $stable(tap_valid)
			&& $stable(tap_x) && $stable(tap_y))
		else $error("result changed while stalled");

	// never a tap and a zoom in one item
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tap_valid |-> zoom_step == ZoomNone)
		else $error("tap and zoom in one item");

	a_tap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tap_valid |-> tap_x == '0 && tap_y == '0)
		else $error("tap coordinates without tap");

	// a full result stage with no take leaves room for at most one more item
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready)
		else $error("input taken past a full pipeline");

endmodule

bind two_touch_pinch_tracker ttpt_checker u_ttpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.zoom_step (zoom_step),
	.tap_valid (tap_valid),
	.tap_x     (tap_x),
	.tap_y     (tap_y)
);

// ----- sim/tb_two_touch_pinch_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_two_touch_pinch_tracker
// Drives touch events through the tracker and checks every result against an
// in-bench model of the two contact slots, the pinch reference and the tap
// logic. A short directed run covers the corner cases, then random gestures
// run under several pinch thresholds with random gaps on both sides in all but one phase.
// ----------------------------------------------------------------------------
module tb_two_touch_pinch_tracker;
	import ttpt_pkg::*;

	typedef struct {
		logic signed [1:0] zoom;
		logic              tap;
		coord_t            x;
		coord_t            y;
	} touch_result_t;

	class pinch_scoreboard;
		bit                   active [2];
		logic [IdBits-1:0]    contact [2];
		int                   sx [2];
		int                   sy [2];
		int                   reference;
		bit                   pinching;
		logic [ThreshBits-1:0] threshold;
		touch_result_t        expected_results [$];
		int                   mismatches;

		function new();
			for (int i = 0; i < 2; i++) begin
				active[i]  = 1'b0;
				contact[i] = '0;
				sx[i]      = 0;
				sy[i]      = 0;
			end
			reference  = 0;
			pinching   = 1'b0;
			threshold  = ThreshReset;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function int spread();
			int ax;
			int ay;
			ax = (sx[0] > sx[1]) ? sx[0] - sx[1] : sx[1] - sx[0];
			ay = (sy[0] > sy[1]) ? sy[0] - sy[1] : sy[1] - sy[0];
			return (ax > ay) ? ax + (ay >> 1) : ay + (ax >> 1);
		endfunction

		function void note_event(kind_t k, logic [IdBits-1:0] id, coord_t x, coord_t y,
				logic en);
			touch_result_t r;
			int s;
			int d;
			int th;
			r.zoom = ZoomNone;
			r.tap  = 1'b0;
			r.x    = '0;
			r.y    = '0;
			s = -1;
			for (int i = 0; i < 2; i++)
				if (active[i] && contact[i] == id)
					s = i;
			if (k == KIND_DOWN) begin
				if (s < 0) begin
					if (!active[0])
						s = 0;
					else if (!active[1])
						s = 1;
				end
				if (s >= 0) begin
					active[s]  = 1'b1;
					contact[s] = id;
					sx[s]      = x;
					sy[s]      = y;
					if (active[0] && active[1]) begin
						reference = spread();
						pinching  = 1'b1;
					end else begin
						pinching = 1'b0;
					end
				end
			end else if (s >= 0) begin
				sx[s] = x;
				sy[s] = y;
				if (k == KIND_MOVE) begin
					if (active[0] && active[1] && en) begin
						d  = spread();
						th = (threshold == 0) ? 1 : int'(threshold);
						if (d >= reference && d - reference >= th) begin
							r.zoom    = ZoomIn;
							reference = d;
						end else if (d < reference && reference - d >= th) begin
							r.zoom    = ZoomOut;
							reference = d;
						end
					end
				end else begin
					active[s] = 1'b0;
					if (k == KIND_CANCEL || pinching) begin
						if (!active[0] && !active[1])
							pinching = 1'b0;
					end else begin
						r.tap = 1'b1;
						r.x   = x;
						r.y   = y;
					end
				end
			end
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("ERROR: %s", what);
		endtask

		task check_result(logic signed [1:0] z, logic t, coord_t x, coord_t y);
			touch_result_t e;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no event outstanding");
				return;
			end
			e = expected_results.pop_front();
			if (z !== e.zoom)
				report_mismatch($sformatf("zoom_step %0d, expected %0d", z, e.zoom));
			if (t !== e.tap)
				report_mismatch($sformatf("tap_valid %b, expected %b", t, e.tap));
			if (x !== e.x)
				report_mismatch($sformatf("tap_x %0d, expected %0d", x, e.x));
			if (y !== e.y)
				report_mismatch($sformatf("tap_y %0d, expected %0d", y, e.y));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [ThreshBits-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            kind = KIND_DOWN;
	logic [IdBits-1:0]     contact_id = '0;
	coord_t                pos_x = '0;
	coord_t                pos_y = '0;
	logic                  pinch_enabled = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [1:0]     zoom_step;
	logic                  tap_valid;
	coord_t                tap_x;
	coord_t                tap_y;

	pinch_scoreboard board = new();
	bit              no_gaps = 1'b0;
	int              events_sent = 0;

	two_touch_pinch_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.contact_id    (contact_id),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pinch_enabled (pinch_enabled),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.zoom_step     (zoom_step),
		.tap_valid     (tap_valid),
		.tap_x         (tap_x),
		.tap_y         (tap_y)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(zoom_step, tap_valid, tap_x, tap_y);
	end

	task automatic send_event(input kind_t ev_kind, input int id, input int x, input int y,
			input bit en);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= ev_kind;
		contact_id    <= IdBits'(id);
		pos_x         <= CoordBits'(x);
		pos_y         <= CoordBits'(y);
		pinch_enabled <= en;
		do @(posedge clk); while (!in_ready);
		board.note_event(kind_t'(kind), contact_id, pos_x, pos_y, pinch_enabled);
		events_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= ThreshBits'(value);
		do @(posedge clk); while (!cfg_ready);
		board.threshold = cfg_data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int nudge(input int v, input int span);
		int n;
		if ($urandom_range(15) == 0)
			return $urandom_range(4095);
		n = v + int'($urandom_range(2 * span)) - span;
		if (n < 0)
			n = 0;
		if (n > 4095)
			n = 4095;
		return n;
	endfunction

	task automatic run_gesture(input int span);
		int    ids [2];
		int    px [2];
		int    py [2];
		int    c;
		int    first;
		bit    two;
		kind_t rk;
		for (int i = 0; i < 2; i++)
			if (board.active[i] && $urandom_range(3) != 0)
				send_event(KIND_CANCEL, board.contact[i], $urandom_range(4095),
					$urandom_range(4095), 1'($urandom_range(1)));
		for (int i = 0; i < 2; i++) begin
			ids[i] = $urandom_range(255);
			px[i]  = $urandom_range(4095);
			py[i]  = $urandom_range(4095);
		end
		two = ($urandom_range(3) != 0);
		send_event(KIND_DOWN, ids[0], px[0], py[0], 1'($urandom_range(1)));
		if (two)
			send_event(KIND_DOWN, ids[1], px[1], py[1], 1'($urandom_range(1)));
		repeat ($urandom_range(14, 1)) begin
			c = two ? $urandom_range(1) : 0;
			if ($urandom_range(9) == 0) begin
				// noise: any kind, known or stray id
				case ($urandom_range(2))
					0: c = ids[0];
					1: c = ids[1];
					default: c = $urandom_range(255);
				endcase
				send_event(kind_t'($urandom_range(3)), c, $urandom_range(4095),
					$urandom_range(4095), 1'($urandom_range(1)));
			end else begin
				px[c] = nudge(px[c], span);
				py[c] = nudge(py[c], span);
				send_event(KIND_MOVE, ids[c], px[c], py[c], $urandom_range(9) != 0);
			end
		end
		if ($urandom_range(7) == 0)
			return;
		first = two ? $urandom_range(1) : 0;
		for (int n = 0; n < (two ? 2 : 1); n++) begin
			c     = (n == 0) ? first : 1 - first;
			rk    = ($urandom_range(4) == 0) ? KIND_CANCEL : KIND_UP;
			px[c] = nudge(px[c], span);
			py[c] = nudge(py[c], span);
			send_event(rk, ids[c], px[c], py[c], 1'($urandom_range(1)));
		end
	endtask

	initial begin
		#(12 * 400_000);
		$display("FAIL");
		$finish;
	end

	initial begin
		int thresholds [7];
		int goal;
		int span;
		thresholds = '{0, 8191, 1, 6143, 2, int'($urandom_range(6143, 1)),
			int'($urandom_range(60, 3))};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset threshold of 20
		send_event(KIND_MOVE,   42,  4095, 4095, 1);
		send_event(KIND_UP,     255, 0,    0,    0);
		send_event(KIND_CANCEL, 0,   4095, 0,    1);
		send_event(KIND_DOWN,   0,   0,    0,    0);
		send_event(KIND_DOWN,   0,   10,   10,   1);
		send_event(KIND_MOVE,   0,   20,   20,   1);
		send_event(KIND_UP,     0,   4095, 4095, 0);
		send_event(KIND_DOWN,   255, 0,    0,    1);
		send_event(KIND_DOWN,   7,   4095, 4095, 1);
		send_event(KIND_DOWN,   9,   100,  100,  1);
		send_event(KIND_MOVE,   7,   4095, 0,    1);
		send_event(KIND_MOVE,   7,   10,   0,    0);
		send_event(KIND_MOVE,   7,   30,   0,    1);
		send_event(KIND_MOVE,   7,   50,   0,    1);
		send_event(KIND_MOVE,   7,   69,   0,    1);
		send_event(KIND_MOVE,   255, 0,    31,   1);
		send_event(KIND_DOWN,   7,   100,  0,    1);
		send_event(KIND_UP,     7,   100,  0,    1);
		send_event(KIND_UP,     255, 5,    5,    1);
		send_event(KIND_DOWN,   3,   1,    2,    1);
		send_event(KIND_DOWN,   4,   3,    4,    1);
		send_event(KIND_CANCEL, 4,   5,    6,    0);
		send_event(KIND_CANCEL, 3,   7,    8,    1);
		send_event(KIND_DOWN,   5,   123,  456,  0);
		send_event(KIND_UP,     5,   2048, 1024, 0);

		goal = events_sent;
		for (int p = 0; p < 7; p++) begin
			wait_for_results();
			write_threshold(thresholds[p]);
			no_gaps = (p == 3);
			goal += 250;
			while (events_sent < goal) begin
				case ($urandom_range(3))
					0: span = $urandom_range(8, 1);
					1: span = 2048;
					default: span = $urandom_range(400, 8);
				endcase
				run_gesture(span);
			end
		end
		no_gaps = 1'b0;

		wait_for_results();
		if (board.pending() != 0)
			board.report_mismatch("events left without a result");
		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ttpt_pkg.sv
design/two_touch_pinch_tracker.sv
design/ttpt_checker.sv
sim/tb_two_touch_pinch_tracker.sv
